FILE: hdl/utc_to_local_time_with_dst_unit_assert.svh
// Assertion macros for the UTC to local time unit checker
`ifndef UTC_TO_LOCAL_TIME_WITH_DST_UNIT_ASSERT_SVH
`define UTC_TO_LOCAL_TIME_WITH_DST_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define UTCL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("utcl check failed");

// Same-cycle implication
`define UTCL_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utcl check failed");

// Next-cycle implication
`define UTCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utcl check failed");

`endif

FILE: hdl/utcl_pkg.sv
// Package: types, constants and calendar helpers for the UTC to local time unit
`default_nettype none

package utcl_pkg;

    localparam int TABLE_YEARS_DEF = 4;
    localparam int YEAR_W          = 12;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    localparam int HOUR_W          = 5;
    localparam int OFFSET_W        = 5;
    localparam int MMDD_W          = 11;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 2 * MMDD_W;

    localparam int HOURS_PER_DAY   = 24;
    localparam int MMDD_SCALE      = 100;
    localparam int LEAP_PERIOD     = 4;
    localparam int LEAP_FEB_DAYS   = 29;
    localparam int MONTHS_PER_YEAR = 12;
    localparam int FIRST_YEAR_RST  = 2000;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'(MONTHS_PER_YEAR);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STD_OFFSET = 3'd0,
        REG_DST_OFFSET = 3'd1,
        REG_FIRST_YEAR = 3'd2,
        REG_WINDOW_0   = 3'd3,
        REG_WINDOW_1   = 3'd4,
        REG_WINDOW_2   = 3'd5,
        REG_WINDOW_3   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  utc_year;
        logic [MONTH_W-1:0] utc_month;
        logic [DAY_W-1:0]   utc_day;
        logic [HOUR_W-1:0]  utc_hour;
    } utc_in_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  local_year;
        logic [MONTH_W-1:0] local_month;
        logic [DAY_W-1:0]   local_day;
        logic [HOUR_W-1:0]  local_hour;
        logic               dst_active;
        logic               year_not_in_table;
    } local_out_t;

    // DST window of one table year, same layout as the register
    typedef struct packed {
        logic [MMDD_W-1:0] end_mmdd;
        logic [MMDD_W-1:0] begin_mmdd;
    } window_t;

    // Scalar settings shared by the register file and the datapath
    typedef struct packed {
        logic signed [OFFSET_W-1:0] std_offset;
        logic signed [OFFSET_W-1:0] dst_offset;
        logic [YEAR_W-1:0]          first_table_year;
    } cfg_t;

    // Month length; months without meaning count as 31 days
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_FEB: len = leap ? 5'(LEAP_FEB_DAYS) : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/utc_to_local_time_with_dst_unit.sv
// Accepted beats pass through the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; the input register and
// the result register form a two-stage pipeline around the whole conversion.
// in_stall rises only when both stages hold beats and out_stall is high.
// Reset (rst_n low, asynchronous) empties both stages and returns the
// configuration to offsets 0, base year 2000 and empty DST windows.
`default_nettype none

module utc_to_local_time_with_dst_unit
    import utcl_pkg::*;
#(
    parameter int TABLE_YEARS = TABLE_YEARS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire utc_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output local_out_t                 out_data
);

    cfg_t       cfg;
    window_t    windows [TABLE_YEARS];
    utc_in_t    in_reg;
    logic       in_valid_reg;
    local_out_t out_reg;
    logic       out_valid_reg;
    local_out_t result;
    logic       in_take;
    logic       out_load;

    utcl_cfg #(
        .TABLE_YEARS (TABLE_YEARS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .windows   (windows)
    );

    utcl_conv #(
        .TABLE_YEARS (TABLE_YEARS)
    ) u_conv (
        .item    (in_reg),
        .cfg     (cfg),
        .windows (windows),
        .result  (result)
    );

    // Pipeline flow control
    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/utcl_cfg.sv
// Configuration register file: offsets, table base year and DST windows
`default_nettype none

module utcl_cfg
    import utcl_pkg::*;
#(
    parameter int TABLE_YEARS = TABLE_YEARS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg,
    output window_t                    windows [TABLE_YEARS]
);

    cfg_t    cfg_reg;
    window_t window_reg [TABLE_YEARS];

    // Scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.std_offset       <= '0;
            cfg_reg.dst_offset       <= '0;
            cfg_reg.first_table_year <= YEAR_W'(FIRST_YEAR_RST);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_STD_OFFSET)
            begin
                cfg_reg.std_offset <= $signed(cfg_data[OFFSET_W-1:0]);
            end
            if (cfg_index == REG_DST_OFFSET)
            begin
                cfg_reg.dst_offset <= $signed(cfg_data[OFFSET_W-1:0]);
            end
            if (cfg_index == REG_FIRST_YEAR)
            begin
                cfg_reg.first_table_year <= cfg_data[YEAR_W-1:0];
            end
        end
    end

    // One window register per table year
    for (genvar i = 0; i < TABLE_YEARS; i++)
    begin : g_window
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                window_reg[i] <= '0;
            end
            else if (cfg_wr_en && (cfg_index == CFG_IDX_W'(int'(REG_WINDOW_0) + i)))
            begin
                window_reg[i] <= cfg_data;
            end
        end
        assign windows[i] = window_reg[i];
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hdl/utcl_conv.sv
// Conversion datapath: DST window test, hour offset and calendar roll
`default_nettype none

module utcl_conv
    import utcl_pkg::*;
#(
    parameter int TABLE_YEARS = TABLE_YEARS_DEF
) (
    input  wire utc_in_t    item,
    input  wire cfg_t       cfg,
    input  wire window_t    windows [TABLE_YEARS],
    output local_out_t      result
);

    logic [YEAR_W-1:0]          year_diff;
    logic                       in_table;
    window_t                    win;
    logic [MMDD_W-1:0]          mmdd;
    logic                       dst;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [HOUR_W+1:0]   hour_sum;
    logic                       leap;
    logic [DAY_W-1:0]           days_cur;
    logic [YEAR_W-1:0]          year;
    logic [MONTH_W-1:0]         month;
    logic [DAY_W-1:0]           day;
    logic [HOUR_W-1:0]          hour;

    // Table lookup for the input year
    assign year_diff = item.utc_year - cfg.first_table_year;
    assign in_table  = (item.utc_year >= cfg.first_table_year)
                    && (year_diff < YEAR_W'(TABLE_YEARS));

    always_comb
    begin
        win = '0;
        for (int i = 0; i < TABLE_YEARS; i++)
        begin
            if (year_diff == YEAR_W'(i))
            begin
                win = windows[i];
            end
        end
    end

    // Window test: begin inclusive, end exclusive
    assign mmdd = MMDD_W'(item.utc_month) * MMDD_W'(MMDD_SCALE) + MMDD_W'(item.utc_day);
    assign dst  = in_table && (mmdd >= win.begin_mmdd) && (mmdd < win.end_mmdd);

    // Hour plus offset, range -16..46
    assign offset   = dst ? cfg.dst_offset : cfg.std_offset;
    assign hour_sum = $signed({2'b00, item.utc_hour}) + (HOUR_W+2)'(offset);

    assign leap     = (item.utc_year % LEAP_PERIOD) == 0;
    assign days_cur = days_in(item.utc_month, leap);

    // At most one roll, backward or forward
    always_comb
    begin
        year  = item.utc_year;
        month = item.utc_month;
        day   = item.utc_day;
        hour  = hour_sum[HOUR_W-1:0];
        priority if (hour_sum < 0)
        begin
            hour = HOUR_W'(hour_sum + (HOUR_W+2)'(HOURS_PER_DAY));
            if (item.utc_day <= DAY_W'(1))
            begin
                if (item.utc_month == MONTH_JAN)
                begin
                    month = MONTH_DEC;
                    year  = item.utc_year - YEAR_W'(1);
                end
                else
                begin
                    month = item.utc_month - MONTH_W'(1);
                end
                day = days_in(month, leap);
            end
            else
            begin
                day = item.utc_day - DAY_W'(1);
            end
        end
        else if (hour_sum >= (HOUR_W+2)'(HOURS_PER_DAY))
        begin
            hour = HOUR_W'(hour_sum - (HOUR_W+2)'(HOURS_PER_DAY));
            if (({1'b0, item.utc_day} + (DAY_W+1)'(1)) > {1'b0, days_cur})
            begin
                day = DAY_W'(1);
                if (item.utc_month >= MONTH_DEC)
                begin
                    month = MONTH_JAN;
                    year  = item.utc_year + YEAR_W'(1);
                end
                else
                begin
                    month = item.utc_month + MONTH_W'(1);
                end
            end
            else
            begin
                day = item.utc_day + DAY_W'(1);
            end
        end
        else
        begin
            hour = hour_sum[HOUR_W-1:0];
        end
    end

    assign result.local_year        = year;
    assign result.local_month       = month;
    assign result.local_day         = day;
    assign result.local_hour        = hour;
    assign result.dst_active        = dst;
    assign result.year_not_in_table = !in_table;

endmodule

`default_nettype wire

FILE: hdl/utcl_chk.sv
// Port-level checker for the UTC to local time unit, bound to the top level
`default_nettype none

`include "utc_to_local_time_with_dst_unit_assert.svh"

module utcl_chk
    import utcl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire local_out_t out_data
);

    // A stalled result beat holds its value
    `UTCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Input backs up only when the result side is full and stalled
    `UTCL_ASSERT_IMPLIES(a_stall_cause, in_stall, out_valid && out_stall)

    // Local hour always lands in a day
    `UTCL_ASSERT_IMPLIES(a_hour_range, out_valid, out_data.local_hour < HOUR_W'(HOURS_PER_DAY))

    // DST is never applied to a year without a table entry
    `UTCL_ASSERT_ALWAYS(a_dst_table, !(out_valid && out_data.dst_active
                                       && out_data.year_not_in_table))

endmodule

bind utc_to_local_time_with_dst_unit utcl_chk u_chk (.*);

`default_nettype wire
